FILE: src/lrps_pkg.sv
`timescale 1ns / 1ps
package lrps_pkg;
  localparam int NUM_LEGS = 4;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_CAPTURE = 2'd1;
  localparam logic [1:0] KIND_ENTER = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  localparam logic [1:0] MODE_FOLD = 2'd0;
  localparam logic [1:0] MODE_STAND = 2'd1;
  localparam logic [1:0] MODE_ROLL = 2'd2;
  localparam logic [1:0] MODE_DONE = 2'd3;

  localparam logic [2:0] CFG_BASE = 3'd0;
  localparam logic [2:0] CFG_MAXLEG = 3'd1;
  localparam logic [2:0] CFG_FOLD_RAMP = 3'd2;
  localparam logic [2:0] CFG_FOLD_SETTLE = 3'd3;
  localparam logic [2:0] CFG_STAND_RAMP = 3'd4;
  localparam logic [2:0] CFG_STAND_SETTLE = 3'd5;
  localparam logic [2:0] CFG_ROLL_RAMP = 3'd6;
  localparam logic [2:0] CFG_ROLL_SETTLE = 3'd7;

  typedef struct packed {
    logic       load_item;
    logic       emit_start;
    logic       copy_start;
    logic [1:0] copy_src;
    logic [1:0] table_sel;
    logic [10:0] ramp;
    logic [11:0] count;
    logic [1:0] mode;
  } lrps_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lrps_status_t;
endpackage

FILE: src/legged_recovery_pose_sequencer.sv
`timescale 1ns / 1ps
// Recovery pose sequencer. One item is handled at a time. Load and capture items
// write one pose memory word; an enter item copies the measured pose into the
// start pose. A tick in fold or roll mode, or in stand mode up to its threshold,
// emits twelve joint commands; each joint is read from the single pose memory and
// scaled by a one-bit-a-cycle restoring divider shared by all joints, and a tick
// can be held by output stalls. A tick that moves on to another active mode adds a
// copy of the new start pose.
module legged_recovery_pose_sequencer import lrps_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] kind,
  input  logic [1:0] pose_select,
  input  logic [3:0] joint_index,
  input  logic signed [ANGLE_BITS-1:0] joint_value,
  input  logic [11:0] height_mm,
  input  logic upside_down,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [11:0] cfg_data,
  output logic out_valid,
  input  logic out_ready,
  output logic is_command,
  output logic [3:0] joint_number,
  output logic signed [ANGLE_BITS-1:0] joint_command,
  output logic [1:0] mode,
  output logic finished,
  output logic last
);
  lrps_cmd_t cmd;
  lrps_status_t status;
  logic stat_valid, dp_valid, dp_last;
  logic [3:0] dp_joint;
  logic signed [ANGLE_BITS-1:0] dp_cmd;
  logic [1:0] dp_mode;

  lrps_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .height_mm(height_mm), .upside_down(upside_down), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd),
    .status(status), .stat_valid(stat_valid), .stat_ready(out_ready)
  );

  lrps_datapath #(.ANGLE_BITS(ANGLE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .pose_select(pose_select),
    .joint_index(joint_index), .joint_value(joint_value), .kind(kind),
    .out_valid(dp_valid), .out_ready(out_ready), .joint_number(dp_joint),
    .joint_command(dp_cmd), .cmd_mode(dp_mode), .out_last(dp_last)
  );

  assign out_valid = dp_valid || stat_valid;
  assign is_command = dp_valid;
  assign joint_number = dp_valid ? dp_joint : 4'd0;
  assign joint_command = dp_valid ? dp_cmd : '0;
  assign mode = dp_valid ? dp_mode : MODE_DONE;
  assign finished = !dp_valid;
  assign last = dp_valid ? dp_last : 1'b1;
endmodule

FILE: src/lrps_ram.sv
`timescale 1ns / 1ps
module lrps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/lrps_datapath.sv
`timescale 1ns / 1ps
module lrps_datapath import lrps_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  lrps_cmd_t cmd,
  output lrps_status_t status,
  input  logic [1:0] pose_select,
  input  logic [3:0] joint_index,
  input  logic signed [ANGLE_BITS-1:0] joint_value,
  input  logic [1:0] kind,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] joint_number,
  output logic signed [ANGLE_BITS-1:0] joint_command,
  output logic [1:0] cmd_mode,
  output logic out_last
);
  localparam int NJ = NUM_LEGS * 3;
  localparam int DEPTH = NJ * 5;
  localparam int AW = $clog2(DEPTH);
  localparam int JW = $clog2(NJ + 1);
  localparam int PW = ANGLE_BITS + 1 + 12;
  localparam int QW = PW;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_LATCH = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;
  localparam logic [2:0] S_COPY = 3'd5;
  localparam logic [2:0] S_CRD = 3'd6;
  localparam logic [1:0] SRC_START = 2'd3;
  localparam logic [1:0] SRC_MEAS = 2'd3;

  // memory layout: tables 0..2, measured at 3, start at 4 (each NJ words)
  logic [2:0] state, state_next;
  logic [JW-1:0] j;
  logic [1:0] phase;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [ANGLE_BITS-1:0] wdata, rdata;
  logic signed [ANGLE_BITS-1:0] s_val, t_val;
  logic neg;
  logic [PW-1:0] rem, quo;
  logic [$clog2(PW+1)-1:0] bitc;
  logic [10:0] ramp;
  logic [11:0] count;
  logic [1:0] tsel, csrc;
  lrps_cmd_t c;

  lrps_ram #(.WIDTH(ANGLE_BITS), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] addr(input logic [2:0] tb, input logic [JW-1:0] jj);
    addr = AW'(int'(tb) * NJ + int'(jj));
  endfunction

  logic signed [ANGLE_BITS:0] diff;
  logic [ANGLE_BITS:0] mag;
  logic [PW-1:0] prod;
  logic [PW:0] trial;
  logic signed [PW:0] sq;
  assign diff = (ANGLE_BITS+1)'(t_val) - (ANGLE_BITS+1)'(s_val);
  assign mag = diff[ANGLE_BITS] ? (ANGLE_BITS+1)'(-diff) : diff;
  assign prod = PW'(mag) * PW'(count);
  assign trial = {rem, quo[PW-1]} - (PW+1)'(ramp);
  assign sq = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_comb begin
    we = 1'b0;
    waddr = addr(3'd4, j);
    wdata = rdata;
    raddr = addr(3'd4, j);
    state_next = state;
    if (state == S_IDLE && cmd.load_item) begin
      if (kind == KIND_LOAD && pose_select != 2'd3 && int'(joint_index) < NJ) begin
        we = 1'b1;
        waddr = addr({1'b0, pose_select}, JW'(joint_index));
        wdata = joint_value;
      end else if (kind == KIND_CAPTURE && int'(joint_index) < NJ) begin
        we = 1'b1;
        waddr = addr(3'd3, JW'(joint_index));
        wdata = joint_value;
      end
    end
    case (state)
      S_IDLE: begin
        if (cmd.emit_start) begin
          state_next = S_RD;
        end else if (cmd.copy_start) begin
          state_next = S_CRD;
        end
      end
      S_RD: begin
        raddr = phase[0] ? addr({1'b0, tsel}, j) : addr(3'd4, j);
        if (phase == 2'd2) begin
          state_next = S_LATCH;
        end
      end
      S_LATCH: state_next = S_DIV;
      S_DIV: begin
        if (int'(bitc) == PW - 1) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = (int'(j) == NJ - 1) ? S_IDLE : S_RD;
        end
      end
      S_CRD: begin
        raddr = addr({1'b0, csrc}, j);
        if (phase == 2'd1) begin
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        we = 1'b1;
        waddr = addr(3'd4, j);
        wdata = rdata;
        state_next = (int'(j) == NJ - 1) ? S_IDLE : S_CRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          j <= '0;
          phase <= '0;
          c <= cmd;
          tsel <= cmd.table_sel;
          csrc <= cmd.copy_src;
          ramp <= cmd.ramp;
          count <= cmd.count;
        end
        S_RD: begin
          phase <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
          if (phase == 2'd1) begin
            s_val <= rdata;
          end
          if (phase == 2'd2) begin
            t_val <= rdata;
          end
        end
        S_LATCH: begin
          neg <= diff[ANGLE_BITS];
          quo <= prod;
          rem <= '0;
          bitc <= '0;
        end
        S_DIV: begin
          bitc <= bitc + 1'b1;
          if (!trial[PW]) begin
            rem <= trial[PW-1:0];
            quo <= {quo[PW-2:0], 1'b1};
          end else begin
            rem <= {rem[PW-2:0], quo[PW-1]};
            quo <= {quo[PW-2:0], 1'b0};
          end
        end
        S_OUT: begin
          if (out_ready) begin
            j <= j + 1'b1;
          end
        end
        S_CRD: phase <= phase + 2'd1;
        S_COPY: begin
          phase <= '0;
          j <= j + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // last step of the divider fills the final quotient bit
  logic signed [ANGLE_BITS-1:0] res;
  always_comb begin
    if (count >= 12'(ramp)) begin
      res = t_val;
    end else begin
      res = ANGLE_BITS'(sq + (PW+1)'(s_val));
    end
  end

  assign out_valid = (state == S_OUT);
  assign joint_number = 4'(j);
  assign joint_command = res;
  assign cmd_mode = c.mode;
  assign out_last = (int'(j) == NJ - 1);
  assign status.busy = (state != S_IDLE);
  assign status.done = (state == S_OUT && out_ready && int'(j) == NJ - 1)
                       || (state == S_COPY && int'(j) == NJ - 1);
  logic unused;
  assign unused = ^{SRC_START, SRC_MEAS, c.load_item, c.emit_start, c.copy_start,
                    c.copy_src, c.table_sel, c.ramp, c.count};
endmodule

FILE: src/lrps_ctrl.sv
`timescale 1ns / 1ps
module lrps_ctrl import lrps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] kind,
  input  logic [11:0] height_mm,
  input  logic upside_down,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [11:0] cfg_data,
  output lrps_cmd_t cmd,
  input  lrps_status_t status,
  output logic stat_valid,
  input  logic stat_ready
);
  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_EMIT = 2'd1;
  localparam logic [1:0] C_COPY = 2'd2;
  localparam logic [1:0] C_STAT = 2'd3;

  logic [11:0] base_height, max_leg_length;
  logic [10:0] fold_ramp, fold_settle, stand_ramp, stand_settle, roll_ramp, roll_settle;
  logic [1:0] st, mode;
  logic [11:0] tick_count;
  logic up_l;
  logic [1:0] pend_src;
  logic pend_copy;
  logic [11:0] thr;
  logic [15:0] thr_p;

  assign cfg_ready = 1'b1;
  assign in_ready = (st == C_IDLE) && !status.busy;
  logic acc;
  assign acc = in_valid && in_ready;
  assign thr_p = (16'(stand_ramp) + 16'(stand_settle)) * 16'd7;
  assign thr = 12'(({16'd0, thr_p} * 32'd52429) >> 19);
  assign stat_valid = (st == C_STAT);

  logic [12:0] nc;
  assign nc = 13'(tick_count) + 13'd1;

  always_comb begin
    cmd = '0;
    cmd.load_item = acc;
    cmd.count = tick_count;
    cmd.mode = mode;
    case (mode)
      MODE_FOLD: begin
        cmd.table_sel = 2'd1;
        cmd.ramp = fold_ramp;
      end
      MODE_STAND: begin
        cmd.table_sel = 2'd0;
        cmd.ramp = stand_ramp;
      end
      default: begin
        cmd.table_sel = 2'd2;
        cmd.ramp = roll_ramp;
      end
    endcase
    cmd.emit_start = (st == C_EMIT);
    cmd.copy_start = (st == C_COPY) && !status.busy;
    cmd.copy_src = pend_src;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_height <= 12'd300;
      max_leg_length <= 12'd400;
      fold_ramp <= 11'd1000;
      fold_settle <= 11'd1000;
      stand_ramp <= 11'd500;
      stand_settle <= 11'd500;
      roll_ramp <= 11'd50;
      roll_settle <= 11'd300;
      st <= C_IDLE;
      mode <= MODE_FOLD;
      tick_count <= '0;
      pend_copy <= 1'b0;
      pend_src <= '0;
      up_l <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BASE: base_height <= cfg_data;
          CFG_MAXLEG: max_leg_length <= cfg_data;
          CFG_FOLD_RAMP: fold_ramp <= cfg_data[10:0];
          CFG_FOLD_SETTLE: fold_settle <= cfg_data[10:0];
          CFG_STAND_RAMP: stand_ramp <= cfg_data[10:0];
          CFG_STAND_SETTLE: stand_settle <= cfg_data[10:0];
          CFG_ROLL_RAMP: roll_ramp <= cfg_data[10:0];
          CFG_ROLL_SETTLE: roll_settle <= cfg_data[10:0];
          default: ;
        endcase
      end
      case (st)
        C_IDLE: begin
          if (acc) begin
            up_l <= upside_down;
            if (kind == KIND_ENTER) begin
              tick_count <= '0;
              pend_src <= 2'd3;
              st <= C_COPY;
              mode <= (!upside_down && base_height < height_mm
                       && 13'(height_mm) < 13'(base_height) + 13'(max_leg_length))
                      ? MODE_STAND : MODE_FOLD;
            end else if (kind == KIND_TICK) begin
              pend_copy <= 1'b0;
              case (mode)
                MODE_FOLD: begin
                  st <= C_EMIT;
                  if (nc[11:0] >= 12'(fold_ramp) + 12'(fold_settle)) begin
                    pend_copy <= 1'b1;
                    pend_src <= 2'd1;
                  end
                end
                MODE_STAND: begin
                  if (tick_count <= thr) begin
                    st <= C_EMIT;
                  end else if (upside_down || height_mm < base_height) begin
                    pend_src <= 2'd3;
                    mode <= MODE_FOLD;
                    tick_count <= '0;
                    st <= C_COPY;
                  end else begin
                    mode <= MODE_DONE;
                  end
                end
                MODE_ROLL: begin
                  st <= C_EMIT;
                  if (13'(nc[11:0]) > 13'(roll_ramp) + 13'(roll_settle)) begin
                    pend_copy <= 1'b1;
                    pend_src <= 2'd2;
                  end
                end
                default: st <= C_STAT;
              endcase
            end
          end
        end
        C_EMIT: begin
          // datapath latches the count this cycle, so it advances here
          st <= pend_copy ? C_COPY : C_IDLE;
          if (pend_copy) begin
            tick_count <= '0;
            mode <= (mode == MODE_ROLL) ? MODE_FOLD : (up_l ? MODE_ROLL : MODE_STAND);
            pend_copy <= 1'b0;
          end else begin
            tick_count <= nc[11:0];
          end
        end
        C_COPY: if (!status.busy) st <= C_IDLE;
        C_STAT: if (stat_ready) st <= C_IDLE;
        default: st <= C_IDLE;
      endcase
    end
  end
endmodule
